// ===== hdl/cantp_pkg.sv =====
package cantp_pkg;

    // Frame type codes from the high nibble of the PCI byte
    typedef enum logic [3:0] {
        FT_SINGLE      = 4'd0,
        FT_FIRST       = 4'd1,
        FT_CONSECUTIVE = 4'd2,
        FT_FLOW        = 4'd3
    } t_frame_type;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_IGNORED = 2'd0,
        KIND_SEGMENT = 2'd1,
        KIND_FC_TX   = 2'd2,
        KIND_FC_RX   = 2'd3
    } t_kind;

    // Received flow status codes
    localparam logic [3:0] FC_STATUS_MAX = 4'd2;

    localparam logic [2:0]  SEG_MAX    = 3'd7;
    localparam logic [2:0]  FF_SEG     = 3'd6;
    localparam logic [11:0] FF_MIN_LEN = 12'd8;
    localparam logic [7:0]  FC_PCI_CTS = 8'h30;
    localparam logic [2:0]  FC_COUNT   = 3'd3;

    typedef logic [6:0][7:0] t_bytes;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] offset;
        logic [2:0]  count;
        t_bytes      bytes;
        logic        message_done;
        logic [1:0]  fc_code;
    } t_result;

    // Zero the bytes at or beyond cnt
    function automatic t_bytes mask_bytes(input t_bytes src, input logic [2:0] cnt);
        t_bytes res;
        for (int i = 0; i < 7; i++) begin
            res[i] = (3'(i) < cnt) ? src[i] : 8'h00;
        end
        return res;
    endfunction

endpackage

// ===== hdl/cantp_if.sv =====
interface cantp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] pci;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [7:0] data3;
    logic [7:0] data4;
    logic [7:0] data5;
    logic [7:0] data6;
    logic       tx_room;

    modport source (output valid, pci, data0, data1, data2, data3, data4, data5, data6,
                    tx_room, input ready);
    modport sink (input valid, pci, data0, data1, data2, data3, data4, data5, data6,
                  tx_room, output ready);
endinterface

interface cantp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] offset;
    logic [2:0]  count;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic        message_done;
    logic [1:0]  fc_code;

    modport source (output valid, kind, offset, count, byte0, byte1, byte2, byte3, byte4,
                    byte5, byte6, message_done, fc_code, input ready);
    modport sink (input valid, kind, offset, count, byte0, byte1, byte2, byte3, byte4,
                  byte5, byte6, message_done, fc_code, output ready);
endinterface

// ===== hdl/can_tp_receive_reassembly_top.sv =====
// Channel    Dir  Modport  Payload
// i_frame    in   sink     pci, data0..data6, tx_room
// o_result   out  source   kind, offset, count, byte0..byte6, message_done, fc_code
//
// One frame is decoded in the cycle it is accepted; its result sits in the
// output register from the next cycle on. Frames are taken every cycle
// while the output register is empty or being drained and no flow-control
// request is pending. An accepted first frame yields two results: the
// flow-control request waits in a pending slot, which holds off new frames.
// Reset (synchronous, active low) empties the output and clears the
// reassembly counters. A stalled output holds its transaction unchanged.
module can_tp_receive_reassembly_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cantp_frame_if.sink           i_frame,
    cantp_result_if.source        o_result
);

    logic [11:0]        r_remaining_len;
    logic [11:0]        r_next_offset;
    logic               r_valid;
    logic               r_fc_pend;
    cantp_pkg::t_result r_res;

    logic [11:0]        n_remaining_len;
    logic [11:0]        n_next_offset;
    logic               n_fc_pend;
    cantp_pkg::t_result n_res;
    cantp_pkg::t_result fc_res;

    logic               in_accept;
    logic               out_take;
    logic [3:0]         ftype;
    logic [3:0]         low;
    logic [11:0]        ff_len;
    logic [2:0]         cnt;
    logic [11:0]        cf_rem;
    cantp_pkg::t_bytes  frame_bytes;
    cantp_pkg::t_bytes  ff_bytes;

    // Accept a frame only when the output slot frees and no second result waits
    assign i_frame.ready = !r_fc_pend && (!r_valid || o_result.ready);
    assign in_accept     = i_frame.valid && i_frame.ready;
    assign out_take      = r_valid && o_result.ready;

    assign ftype  = i_frame.pci[7:4];
    assign low    = i_frame.pci[3:0];
    assign ff_len = {low, i_frame.data0};

    assign frame_bytes = {i_frame.data6, i_frame.data5, i_frame.data4, i_frame.data3,
                          i_frame.data2, i_frame.data1, i_frame.data0};
    assign ff_bytes    = {8'h00, i_frame.data6, i_frame.data5, i_frame.data4,
                          i_frame.data3, i_frame.data2, i_frame.data1};

    // Fixed flow-control frame to send: CTS, block size 0, STmin 0
    always_comb begin
        fc_res          = '0;
        fc_res.kind     = cantp_pkg::KIND_FC_TX;
        fc_res.count    = cantp_pkg::FC_COUNT;
        fc_res.bytes[0] = cantp_pkg::FC_PCI_CTS;
    end

    // Decode the frame and work out the next counters
    always_comb begin
        n_res           = '0;
        n_res.kind      = cantp_pkg::KIND_IGNORED;
        n_remaining_len = r_remaining_len;
        n_next_offset   = r_next_offset;
        n_fc_pend       = 1'b0;
        cnt             = 3'd0;
        cf_rem          = r_remaining_len;
        unique case (ftype)
            cantp_pkg::FT_SINGLE: begin
                // Saturate the length nibble; abandon any message in progress
                cnt                = (low > 4'(cantp_pkg::SEG_MAX)) ? cantp_pkg::SEG_MAX
                                                                    : low[2:0];
                n_res.kind         = cantp_pkg::KIND_SEGMENT;
                n_res.count        = cnt;
                n_res.bytes        = cantp_pkg::mask_bytes(frame_bytes, cnt);
                n_res.message_done = 1'b1;
                n_remaining_len    = 12'd0;
                n_next_offset      = 12'd0;
            end
            cantp_pkg::FT_FIRST: begin
                // Drop without transmit room or with an invalid short length
                if (i_frame.tx_room && (ff_len >= cantp_pkg::FF_MIN_LEN)) begin
                    n_res.kind      = cantp_pkg::KIND_SEGMENT;
                    n_res.count     = cantp_pkg::FF_SEG;
                    n_res.bytes     = ff_bytes;
                    n_fc_pend       = 1'b1;
                    n_remaining_len = ff_len - 12'(cantp_pkg::FF_SEG);
                    n_next_offset   = 12'(cantp_pkg::FF_SEG);
                end
            end
            cantp_pkg::FT_CONSECUTIVE: begin
                // Ignore when no message is in progress
                if (r_remaining_len != 12'd0) begin
                    cnt                = (r_remaining_len > 12'(cantp_pkg::SEG_MAX))
                                         ? cantp_pkg::SEG_MAX : r_remaining_len[2:0];
                    cf_rem             = r_remaining_len - 12'(cnt);
                    n_res.kind         = cantp_pkg::KIND_SEGMENT;
                    n_res.offset       = r_next_offset;
                    n_res.count        = cnt;
                    n_res.bytes        = cantp_pkg::mask_bytes(frame_bytes, cnt);
                    n_res.message_done = (cf_rem == 12'd0);
                    n_remaining_len    = cf_rem;
                    n_next_offset      = r_next_offset + 12'(cnt);
                end
            end
            cantp_pkg::FT_FLOW: begin
                if (low <= cantp_pkg::FC_STATUS_MAX) begin
                    n_res.kind    = cantp_pkg::KIND_FC_RX;
                    n_res.fc_code = low[1:0];
                end
            end
            default: begin
                // Unknown frame types give an ignored result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= 1'b0;
            r_fc_pend       <= 1'b0;
            r_remaining_len <= 12'd0;
            r_next_offset   <= 12'd0;
        end else if (in_accept) begin
            r_valid         <= 1'b1;
            r_fc_pend       <= n_fc_pend;
            r_res           <= n_res;
            r_remaining_len <= n_remaining_len;
            r_next_offset   <= n_next_offset;
        end else if (out_take) begin
            // Advance to the pending flow-control request, else empty the slot
            if (r_fc_pend) begin
                r_res     <= fc_res;
                r_fc_pend <= 1'b0;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.kind         = r_res.kind;
    assign o_result.offset       = r_res.offset;
    assign o_result.count        = r_res.count;
    assign o_result.byte0        = r_res.bytes[0];
    assign o_result.byte1        = r_res.bytes[1];
    assign o_result.byte2        = r_res.bytes[2];
    assign o_result.byte3        = r_res.bytes[3];
    assign o_result.byte4        = r_res.bytes[4];
    assign o_result.byte5        = r_res.bytes[5];
    assign o_result.byte6        = r_res.bytes[6];
    assign o_result.message_done = r_res.message_done;
    assign o_result.fc_code      = r_res.fc_code;

endmodule

// ===== hdl/cantp_checker.sv =====
module cantp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [11:0] i_offset,
    input logic [2:0]  i_count,
    input logic [7:0]  i_byte0,
    input logic        i_message_done,
    input logic [1:0]  i_fc_code
);

    // Hold a stalled transaction
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_offset)
                                && $stable(i_count))
        else $error("stalled result changed");

    // A first-frame segment is followed at once by the flow-control request
    a_ff_then_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && (i_kind == cantp_pkg::KIND_SEGMENT) && (i_offset == 12'd0)
        && (i_count == cantp_pkg::FF_SEG) && !i_message_done
        |=> i_valid && (i_kind == cantp_pkg::KIND_FC_TX))
        else $error("flow-control request missing after first frame");

    a_fc_tx_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == cantp_pkg::KIND_FC_TX)
        |-> (i_count == cantp_pkg::FC_COUNT) && (i_byte0 == cantp_pkg::FC_PCI_CTS))
        else $error("malformed flow-control request");

    a_done_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_message_done |-> (i_kind == cantp_pkg::KIND_SEGMENT))
        else $error("message_done on a non-segment result");

    a_fc_code_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind != cantp_pkg::KIND_FC_RX) |-> (i_fc_code == 2'd0))
        else $error("fc_code set on a result that is not received flow control");

endmodule

bind can_tp_receive_reassembly_top cantp_checker u_cantp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_result.valid),
    .i_ready        (o_result.ready),
    .i_kind         (o_result.kind),
    .i_offset       (o_result.offset),
    .i_count        (o_result.count),
    .i_byte0        (o_result.byte0),
    .i_message_done (o_result.message_done),
    .i_fc_code      (o_result.fc_code)
);
